FILE: src/modulo_hash_key_value_table_unit_defines.svh
// Assertion macros used by the key-value table top level.
`ifndef MODULO_HASH_KEY_VALUE_TABLE_UNIT_DEFINES_SVH
`define MODULO_HASH_KEY_VALUE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MHKVT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MHKVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mhkvt_pkg.sv
// Types and fixed constants of the modulo-hash key-value table.
package mhkvt_pkg;

    localparam int KEY_W       = 31;
    localparam int VALUE_W     = 64;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_REMOVE = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW       = 3'd0,
        ST_REPLACED  = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_LOOK
    } state_t;

    // Outcome of one bucket lookup: row write-back and answer code.
    typedef struct packed {
        logic    wr_en;
        status_t status;
    } resp_t;

endpackage

FILE: src/mhkvt_hash.sv
// Two-stage key modulo BUCKETS unit: reciprocal multiply, then remainder fix-up.
module mhkvt_hash
    import mhkvt_pkg::*;
#(
    parameter int BUCKETS = 16,
    parameter int BW      = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] key,
    output logic             done,
    output logic [BW-1:0]    bucket
);

    localparam int             RW    = BW + 1;
    localparam logic [31:0]    RECIP = 32'((64'd1 << 31) / BUCKETS);
    localparam logic [RW-1:0]  DIV   = RW'(BUCKETS);
    localparam int             PW    = KEY_W + 32;

    logic          v1_reg, v1_next;
    logic          v2_reg, v2_next;
    logic [RW-1:0] q_reg, q_next;
    logic [RW-1:0] klo1_reg, klo1_next;
    logic [RW-1:0] qd_reg, qd_next;
    logic [RW-1:0] klo2_reg, klo2_next;
    logic [PW-1:0] prod;
    logic [RW-1:0] r_est;

    // Quotient estimate is exact or one low, so the remainder is below 2*BUCKETS.
    assign prod      = PW'(key) * PW'(RECIP);
    assign q_next    = prod[31 +: RW];
    assign klo1_next = key[RW-1:0];
    assign qd_next   = q_reg * DIV;
    assign klo2_next = klo1_reg;
    assign v1_next   = start;
    assign v2_next   = v1_reg;

    assign r_est  = klo2_reg - qd_reg;
    assign bucket = (r_est >= DIV) ? BW'(r_est - DIV) : BW'(r_est);
    assign done   = v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        klo1_reg <= klo1_next;
        qd_reg   <= qd_next;
        klo2_reg <= klo2_next;
    end

endmodule

FILE: src/mhkvt_bucket_mem.sv
// Bucket row memory: one write port, one read port with registered data.
module mhkvt_bucket_mem
    import mhkvt_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int WIDTH = 384
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] row_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= row_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/mhkvt_way_match.sv
// Compare all ways of one bucket row and build the updated row and answer.
module mhkvt_way_match
    import mhkvt_pkg::*;
#(
    parameter int WAYS       = 4,
    parameter int VALUE_BITS = 64
)
(
    input  logic [WAYS*(1+KEY_W+VALUE_BITS)-1:0] row,
    input  kind_t                                kind,
    input  logic [KEY_W-1:0]                     key,
    input  logic [VALUE_BITS-1:0]                value,
    output logic [WAYS*(1+KEY_W+VALUE_BITS)-1:0] new_row,
    output resp_t                                resp,
    output logic [VALUE_BITS-1:0]                read_value
);

    localparam int SLOT_W = 1 + KEY_W + VALUE_BITS;
    localparam int KEY_LO = VALUE_BITS;
    localparam int VLD_AT = VALUE_BITS + KEY_W;

    logic [WAYS-1:0] vld;
    logic [WAYS-1:0] match;
    logic [WAYS-1:0] hit_sel;
    logic [WAYS-1:0] free_sel;
    logic            hit;
    logic            has_free;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            vld[w]   = row[w*SLOT_W + VLD_AT];
            match[w] = vld[w] && (row[w*SLOT_W + KEY_LO +: KEY_W] == key);
        end
        // Isolate the lowest set bit: lowest matching and lowest free way.
        hit_sel  = match & (~match + WAYS'(1));
        free_sel = ~vld & (vld + WAYS'(1));
        hit      = |match;
        has_free = ~&vld;

        read_value = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            read_value = read_value
                       | ({VALUE_BITS{hit_sel[w]}} & row[w*SLOT_W +: VALUE_BITS]);
        end

        new_row     = row;
        resp.wr_en  = 1'b0;
        resp.status = ST_NOT_FOUND;
        case (kind)
            KIND_INSERT:
            begin
                resp.wr_en = hit || has_free;
                if (hit)
                begin
                    resp.status = ST_REPLACED;
                end
                else if (has_free)
                begin
                    resp.status = ST_NEW;
                end
                else
                begin
                    resp.status = ST_FULL;
                end
                for (int w = 0; w < WAYS; w++)
                begin
                    if (hit && hit_sel[w])
                    begin
                        new_row[w*SLOT_W +: VALUE_BITS] = value;
                    end
                    else if (!hit && free_sel[w])
                    begin
                        new_row[w*SLOT_W +: SLOT_W] = {1'b1, key, value};
                    end
                end
            end
            KIND_SEARCH:
            begin
                if (hit)
                begin
                    resp.status = ST_FOUND;
                end
            end
            KIND_REMOVE:
            begin
                if (hit)
                begin
                    resp.wr_en  = 1'b1;
                    resp.status = ST_REMOVED;
                end
                for (int w = 0; w < WAYS; w++)
                begin
                    if (hit_sel[w])
                    begin
                        new_row[w*SLOT_W + VLD_AT] = 1'b0;
                    end
                end
            end
            default:
            begin
                resp.wr_en  = 1'b0;
                resp.status = ST_NOT_FOUND;
            end
        endcase
        if (resp.status != ST_FOUND)
        begin
            read_value = '0;
        end
    end

endmodule

FILE: src/modulo_hash_key_value_table_unit.sv
// Top level of the modulo-hash key-value table: control, output register, assertions.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser: kind; tdata: key, value
//  m_*     | out | m_tvalid/m_tready  | tuser: status; tdata: read_value
//
// Requests are taken one at a time: the accept cycle in S_IDLE, the modulo hash in S_HASH
// (reciprocal multiply, then remainder; the bucket row read is issued as the hash completes),
// and way compare and write-back in S_LOOK. No request enters until the write-back is done.
// After reset all BUCKETS rows are cleared, one per cycle; s_tready is low meanwhile.
// While m_tready holds a result back, the write-back cycle waits and no request enters.
`include "modulo_hash_key_value_table_unit_defines.svh"

module modulo_hash_key_value_table_unit
    import mhkvt_pkg::*;
#(
    parameter int BUCKETS    = 16,
    parameter int WAYS       = 4,
    parameter int VALUE_BITS = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // key[30:0], value[94:31], zero pad[95]
    input  logic [KIND_W-1:0]      s_tuser,   // kind[1:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // read_value[63:0]
    output logic [STATUS_W-1:0]    m_tuser    // status[2:0]
);

    localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SLOT_W = 1 + KEY_W + VALUE_BITS;
    localparam int ROW_W  = WAYS * SLOT_W;

    state_t                 state_reg, state_next;
    logic [BW-1:0]          clr_reg, clr_next;
    logic [BW-1:0]          bucket_reg, bucket_next;
    kind_t                  kind_reg, kind_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [VALUE_BITS-1:0]  value_reg, value_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    status_t                status_reg, status_next;
    logic [OUT_TDATA_W-1:0] rdval_reg, rdval_next;

    logic                   accept;
    logic                   hash_done;
    logic [BW-1:0]          hash_bucket;
    logic                   mem_wr_en;
    logic [BW-1:0]          mem_wr_addr;
    logic [ROW_W-1:0]       mem_wr_data;
    logic                   mem_rd_en;
    logic [ROW_W-1:0]       mem_rd_data;
    logic [ROW_W-1:0]       new_row;
    resp_t                  resp;
    logic [VALUE_BITS-1:0]  read_value;
    logic                   load_out;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = rdval_reg;
    assign m_tuser  = status_reg;

    mhkvt_hash #(
        .BUCKETS (BUCKETS),
        .BW      (BW)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .key    (s_tdata[KEY_W-1:0]),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    mhkvt_bucket_mem #(
        .DEPTH (BUCKETS),
        .AW    (BW),
        .WIDTH (ROW_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (hash_bucket),
        .rd_data (mem_rd_data)
    );

    mhkvt_way_match #(
        .WAYS       (WAYS),
        .VALUE_BITS (VALUE_BITS)
    ) u_match (
        .row        (mem_rd_data),
        .kind       (kind_reg),
        .key        (key_reg),
        .value      (value_reg),
        .new_row    (new_row),
        .resp       (resp),
        .read_value (read_value)
    );

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        bucket_next = bucket_reg;
        kind_next   = kind_reg;
        key_next    = key_reg;
        value_next  = value_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = bucket_reg;
        mem_wr_data = new_row;
        mem_rd_en   = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                // Sweep every row to all-invalid.
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg;
                mem_wr_data = '0;
                if (clr_reg == BW'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + BW'(1);
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next  = kind_t'(s_tuser);
                    key_next   = s_tdata[KEY_W-1:0];
                    value_next = s_tdata[KEY_W +: VALUE_BITS];
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    mem_rd_en   = 1'b1;
                    bucket_next = hash_bucket;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK:
            begin
                // Hold the write-back until the output register can take the answer.
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    mem_wr_en  = resp.wr_en;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        status_next   = status_reg;
        rdval_next    = rdval_reg;
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
            status_next   = resp.status;
            rdval_next    = OUT_TDATA_W'(read_value);
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bucket_reg <= bucket_next;
        kind_reg   <= kind_next;
        key_reg    <= key_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        rdval_reg  <= rdval_next;
    end

    `MHKVT_ASSERT_NOW(a_hash_done_in_wait, hash_done, state_reg == S_HASH, "hash result outside hash wait")
    `MHKVT_ASSERT_NOW(a_write_when_owned, mem_wr_en, state_reg == S_CLEAR || state_reg == S_LOOK, "row write outside clear or write-back")
    `MHKVT_ASSERT_NOW(a_no_accept_in_clear, state_reg == S_CLEAR, !s_tready, "request taken during clearing pass")
    `MHKVT_ASSERT_NOW(a_full_no_write, state_reg == S_LOOK && resp.status == ST_FULL, !resp.wr_en, "full bucket wrote a row")
    `MHKVT_ASSERT_NEXT(a_result_loaded, load_out, m_tvalid && state_reg == S_IDLE, "answer not presented after write-back")

endmodule

FILE: sim/modulo_hash_key_value_table_unit_tb.sv
// Self-checking stream testbench for the modulo-hash key-value table with a built-in lookup predictor.
module modulo_hash_key_value_table_unit_tb
    import mhkvt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUCKETS    = 16;
    localparam int WAYS       = 4;
    localparam int VALUE_BITS = 64;
    localparam int SLOTS      = BUCKETS * WAYS;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 400;
    localparam logic [KIND_W-1:0]  KIND_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0]   KEY_MAX     = '1;
    localparam logic [VALUE_W-1:0] VALUE_MASK  =
        (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        int                 gap;
    } request_t;

    typedef struct {
        status_t            status;
        logic [VALUE_W-1:0] read_value;
    } answer_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;   // key[30:0], value[94:31], zero pad[95]
    logic [KIND_W-1:0]      s_tuser = '0;   // kind[1:0]
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;        // read_value[63:0]
    logic [STATUS_W-1:0]    m_tuser;        // status[2:0]

    // Predictor copy of the store
    bit                 slot_used [SLOTS];
    logic [KEY_W-1:0]   slot_tag  [SLOTS];
    logic [VALUE_W-1:0] slot_word [SLOTS];

    request_t pending_requests[$];
    answer_t  answers_due[$];
    request_t staged_req;
    request_t bus_req;
    bit       staged = 1'b0;

    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;
    bit long_hold_done = 1'b0;
    int hold_left = 0;
    int results_seen = 0;
    int fault_count = 0;
    int idle_cycles = 0;

    modulo_hash_key_value_table_unit #(
        .BUCKETS    (BUCKETS),
        .WAYS       (WAYS),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // Look up the bucket, update the store and return the answer for one request.
    function automatic answer_t apply_request(request_t req);
        answer_t ans;
        int base;
        int hit;
        bit placed;
        ans.status = ST_NOT_FOUND;
        ans.read_value = '0;
        base = int'(req.key % BUCKETS) * WAYS;
        hit = -1;
        placed = 1'b0;
        if (req.kind != KIND_UNUSED)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (hit < 0 && slot_used[base + w] && slot_tag[base + w] == req.key)
                    hit = base + w;
            end
        end
        case (req.kind)
            KIND_INSERT:
            begin
                if (hit >= 0)
                begin
                    slot_word[hit] = req.value & VALUE_MASK;
                    ans.status = ST_REPLACED;
                end
                else
                begin
                    ans.status = ST_FULL;
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (!placed && !slot_used[base + w])
                        begin
                            slot_used[base + w] = 1'b1;
                            slot_tag[base + w] = req.key;
                            slot_word[base + w] = req.value & VALUE_MASK;
                            ans.status = ST_NEW;
                            placed = 1'b1;
                        end
                    end
                end
            end
            KIND_SEARCH:
            begin
                if (hit >= 0)
                begin
                    ans.status = ST_FOUND;
                    ans.read_value = slot_word[hit] & VALUE_MASK;
                end
            end
            KIND_REMOVE:
            begin
                if (hit >= 0)
                begin
                    slot_used[hit] = 1'b0;
                    ans.status = ST_REMOVED;
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    function automatic int draw_send_gap();
        int r;
        r = $urandom_range(99);
        if (!send_idle_on || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic queue_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                 logic [VALUE_W-1:0] value);
        request_t req;
        req.kind = kind;
        req.key = key;
        req.value = value;
        req.gap = draw_send_gap();
        pending_requests.push_back(req);
    endtask

    // Crowd a few neighboring buckets with a key pool so that chains fill, hit and drain.
    task automatic queue_random_phase(int count);
        logic [KEY_W-1:0]   pool [24];
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [KIND_W-1:0]  kind;
        int hot;
        int r;
        hot = $urandom_range(0, BUCKETS - 1);
        foreach (pool[i])
        begin
            pool[i] = KEY_W'($urandom);
            pool[i][3:0] = 4'((hot + $urandom_range(0, 4)) % BUCKETS);
        end
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 85)
                key = pool[$urandom_range(0, 23)];
            else
                key = KEY_W'($urandom);
            r = $urandom_range(99);
            if (r < 40)
                kind = KIND_INSERT;
            else if (r < 70)
                kind = KIND_SEARCH;
            else if (r < 95)
                kind = KIND_REMOVE;
            else
                kind = KIND_UNUSED;
            r = $urandom_range(99);
            if (r < 5)
                value = '0;
            else if (r < 10)
                value = '1;
            else
                value = {$urandom, $urandom};
            queue_request(kind, key, value);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_requests.size() != 0 || staged || s_tvalid || answers_due.size() != 0)
            @(negedge clk);
    endtask

    // Driver: present staged requests, record each transfer in the predictor.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                answers_due.push_back(apply_request(bus_req));
            if (!s_tvalid || s_tready)
            begin
                if (!staged && pending_requests.size() != 0)
                begin
                    staged_req = pending_requests.pop_front();
                    staged = 1'b1;
                end
                if (staged && staged_req.gap != 0)
                begin
                    staged_req.gap--;
                    s_tvalid <= 1'b0;
                end
                else if (staged)
                begin
                    bus_req = staged_req;
                    staged = 1'b0;
                    s_tvalid <= 1'b1;
                    s_tdata <= {1'b0, staged_req.value, staged_req.key};
                    s_tuser <= staged_req.kind;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the block up.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                results_seen++;
            if (!long_hold_done && results_seen >= 40)
            begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (recv_idle_on)
                begin
                    if ($urandom_range(99) < 20)
                        hold_left = $urandom_range(1, 3);
                    else if ($urandom_range(99) < 4)
                        hold_left = $urandom_range(15, 60);
                end
            end
        end
    end

    // Monitor: compare each result transfer with the oldest expected answer.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (answers_due.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: status %0d read_value %h", m_tuser, m_tdata);
            end
            else if (m_tuser !== answers_due[0].status
                     || m_tdata !== answers_due[0].read_value)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("mismatch: expected status %0d read_value %h, got status %0d read_value %h",
                             answers_due[0].status, answers_due[0].read_value, m_tuser, m_tdata);
                void'(answers_due.pop_front());
            end
            else
            begin
                void'(answers_due.pop_front());
            end
        end
    end

    // Watchdog: end the run if no transfer happens for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        foreach (slot_used[i])
        begin
            slot_used[i] = 1'b0;
            slot_tag[i] = '0;
            slot_word[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty store, replace, full bucket, way reuse, unused kind, key extremes.
        queue_request(KIND_SEARCH, '0, '1);
        queue_request(KIND_REMOVE, KEY_MAX, '0);
        queue_request(KIND_INSERT, '0, '0);
        queue_request(KIND_INSERT, '0, '1);
        queue_request(KIND_SEARCH, '0, '0);
        queue_request(KIND_INSERT, 31'd16, 64'h0123_4567_89ab_cdef);
        queue_request(KIND_INSERT, 31'd32, 64'h8000_0000_0000_0001);
        queue_request(KIND_INSERT, 31'd48, 64'hfedc_ba98_7654_3210);
        queue_request(KIND_INSERT, 31'd64, 64'h1111_2222_3333_4444);
        queue_request(KIND_INSERT, 31'h7fff_fff0, 64'h5555_5555_5555_5555);
        queue_request(KIND_SEARCH, 31'd64, '0);
        queue_request(KIND_REMOVE, 31'd16, '1);
        queue_request(KIND_INSERT, 31'h7fff_fff0, 64'haaaa_aaaa_aaaa_aaaa);
        queue_request(KIND_SEARCH, 31'h7fff_fff0, '0);
        queue_request(KIND_SEARCH, 31'd32, '0);
        queue_request(KIND_INSERT, KEY_MAX, 64'hffff_0000_ffff_0000);
        queue_request(KIND_SEARCH, KEY_MAX, '0);
        queue_request(KIND_UNUSED, '0, '1);
        queue_request(KIND_UNUSED, KEY_MAX, '1);
        queue_request(KIND_REMOVE, '0, '0);
        queue_request(KIND_SEARCH, '0, '0);
        queue_request(KIND_REMOVE, '0, '0);
        queue_request(KIND_INSERT, 31'h5555_5555, 64'h5555_5555_5555_5555);
        queue_request(KIND_SEARCH, 31'h5555_5555, '0);
        wait_drained();

        // Sender runs back to back here while the receiver takes its long hold.
        send_idle_on = 1'b0;
        queue_random_phase(150);
        wait_drained();

        send_idle_on = 1'b1;
        queue_random_phase(150);
        wait_drained();

        recv_idle_on = 1'b0;
        queue_random_phase(150);
        wait_drained();

        send_idle_on = 1'b0;
        queue_random_phase(150);
        wait_drained();

        repeat (20) @(posedge clk);
        if (fault_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: modulo_hash_key_value_table_unit.f
+incdir+src
src/mhkvt_pkg.sv
src/mhkvt_hash.sv
src/mhkvt_bucket_mem.sv
src/mhkvt_way_match.sv
src/modulo_hash_key_value_table_unit.sv
sim/modulo_hash_key_value_table_unit_tb.sv
